@@ design/bnfc_pkg.sv @@
// Shared types and constants for the binary neighbor filter with bounding-box crop.
`timescale 1ns / 1ps
package bnfc_pkg;

	localparam int WORD_W        = 16;
	localparam int STORE_DEPTH   = 16;
	localparam int CNT_W         = 5;
	localparam int IDX_W         = 4;
	localparam int CFG_W         = 5;
	localparam int CFG_IDX_W     = 1;
	localparam int SURVIVE_LIMIT = 3;
	localparam int NEIGHBORS     = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_ROWS,
		REG_NUM_COLS
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRIME0,
		ST_PRIME1,
		ST_FILT,
		ST_EMIT,
		ST_EMPTY
	} state_t;

	typedef struct packed {
		logic load;
		logic prime0;
		logic prime1;
		logic filt;
		logic emit;
		logic empty;
	} ctrl_cmd_t;

	typedef struct packed {
		logic load_last;
		logic filt_last;
		logic any_kept;
		logic emit_last;
	} dp_status_t;

endpackage

@@ design/bnfc_ctrl.sv @@
// Controller state machine: row loading, filter pass and crop emission sequencing.
`timescale 1ns / 1ps
module bnfc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  bnfc_pkg::dp_status_t   sts,
	output bnfc_pkg::ctrl_cmd_t    cmd
);
	import bnfc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && sts.load_last) begin
					state_d = ST_PRIME0;
				end
			end
			ST_PRIME0: state_d = ST_PRIME1;
			ST_PRIME1: state_d = ST_FILT;
			ST_FILT: begin
				if (sts.filt_last) begin
					state_d = sts.any_kept ? ST_EMIT : ST_EMPTY;
				end
			end
			ST_EMIT: begin
				if (sts.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMPTY: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_PRIME0: cmd.prime0 = 1'b1;
			ST_PRIME1: cmd.prime1 = 1'b1;
			ST_FILT:   cmd.filt   = 1'b1;
			ST_EMIT:   cmd.emit   = 1'b1;
			ST_EMPTY:  cmd.empty  = 1'b1;
			default:   busy       = 1'b1;
		endcase
	end

	a_filt_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILT && sts.filt_last) |=> (state_q == ST_EMIT || state_q == ST_EMPTY))
		else $error("filter pass did not hand over to emission");

	a_empty_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMPTY) |=> (state_q == ST_IDLE))
		else $error("empty result took more than one cycle");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && sts.load_last) |=> (state_q == ST_PRIME0))
		else $error("final row did not start the filter pass");

endmodule

@@ design/bnfc_dp.sv @@
// Datapath: row store, neighbor filter window, bounding box and cropped result register.
`timescale 1ns / 1ps
module bnfc_dp #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bnfc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [bnfc_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic [bnfc_pkg::WORD_W-1:0]     row_bits,
	input  bnfc_pkg::ctrl_cmd_t             cmd,
	output bnfc_pkg::dp_status_t            sts,
	output logic                            result_strobe,
	output logic [bnfc_pkg::WORD_W-1:0]     out_row_bits,
	output logic [bnfc_pkg::CNT_W-1:0]      row_width,
	output logic [bnfc_pkg::IDX_W-1:0]      box_top,
	output logic [bnfc_pkg::IDX_W-1:0]      box_left,
	output logic                            is_last,
	output logic                            is_empty
);
	import bnfc_pkg::*;

	localparam int ROW_CAP = (MAX_ROWS < STORE_DEPTH) ? MAX_ROWS : STORE_DEPTH;
	localparam int COL_CAP = (MAX_COLS < WORD_W) ? MAX_COLS : WORD_W;
	localparam int AW      = (ROW_CAP > 1) ? $clog2(ROW_CAP) : 1;

	logic [CNT_W-1:0]  num_rows_q;
	logic [CNT_W-1:0]  num_cols_q;
	logic [CNT_W-1:0]  nr;
	logic [CNT_W-1:0]  nc;
	logic [CNT_W:0]    nr_x;
	logic [CNT_W-1:0]  rows_loaded_q;
	logic [CNT_W-1:0]  load_idx;
	logic [CNT_W-1:0]  load_next;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W:0]    i_p1;
	logic [CNT_W:0]    i_p2;
	logic [WORD_W-1:0] cmask;

	logic [WORD_W-1:0] store_mem [ROW_CAP];
	logic [WORD_W-1:0] mem_q;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;

	logic [WORD_W-1:0] up_q;
	logic [WORD_W-1:0] cur_q;
	logic [WORD_W-1:0] down_row;
	logic [WORD_W-1:0] west_nb;
	logic [WORD_W-1:0] east_nb;
	logic [WORD_W-1:0] kept;
	logic [IDX_W-1:0]  lo_bit;
	logic [IDX_W-1:0]  hi_bit;

	logic              any_q;
	logic              any_nx;
	logic [IDX_W-1:0]  top_q;
	logic [IDX_W-1:0]  top_nx;
	logic [IDX_W-1:0]  bottom_q;
	logic [IDX_W-1:0]  left_q;
	logic [IDX_W-1:0]  right_q;
	logic [CNT_W-1:0]  width_w;
	logic [WORD_W-1:0] wmask;

	logic              valid_s1;
	logic              last_s1;
	logic              empty_s1;
	logic              strobe_q;
	logic [WORD_W-1:0] out_row_q;
	logic [CNT_W-1:0]  width_q;
	logic [IDX_W-1:0]  top_out_q;
	logic [IDX_W-1:0]  left_out_q;
	logic              last_q;
	logic              empty_q;

	// Counts outside the supported range are pulled back to it.
	always_comb begin
		nr = num_rows_q;
		if (nr == '0) begin
			nr = CNT_W'(1);
		end else if (nr > CNT_W'(ROW_CAP)) begin
			nr = CNT_W'(ROW_CAP);
		end
		nc = num_cols_q;
		if (nc == '0) begin
			nc = CNT_W'(1);
		end else if (nc > CNT_W'(COL_CAP)) begin
			nc = CNT_W'(COL_CAP);
		end
		for (int j = 0; j < WORD_W; j++) begin
			cmask[j] = (CNT_W'(j) < nc);
		end
	end

	assign nr_x      = {1'b0, nr};
	assign load_idx  = (rows_loaded_q >= nr) ? '0 : rows_loaded_q;
	assign load_next = load_idx + CNT_W'(1);
	assign i_p1      = {1'b0, i_q} + (CNT_W + 1)'(1);
	assign i_p2      = {1'b0, i_q} + (CNT_W + 1)'(2);

	// Filter window: cur_q is the row under test, up_q the row above, mem_q the row below.
	assign down_row = (i_p1 < nr_x) ? mem_q : '0;
	assign west_nb  = {cur_q[WORD_W-2:0], 1'b0};
	assign east_nb  = {1'b0, cur_q[WORD_W-1:1]};

	always_comb begin
		logic [2:0] land_cnt;
		for (int j = 0; j < WORD_W; j++) begin
			land_cnt = 3'(up_q[j]) + 3'(down_row[j]) + 3'(west_nb[j]) + 3'(east_nb[j]);
			kept[j]  = cur_q[j] && ((3'(NEIGHBORS) - land_cnt) < 3'(SURVIVE_LIMIT));
		end
	end

	always_comb begin
		lo_bit = '0;
		hi_bit = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (kept[j]) begin
				lo_bit = IDX_W'(j);
			end
		end
		for (int j = 0; j < WORD_W; j++) begin
			if (kept[j]) begin
				hi_bit = IDX_W'(j);
			end
		end
	end

	assign any_nx = any_q | (|kept);
	assign top_nx = any_q ? top_q : i_q[IDX_W-1:0];

	assign sts.load_last = (load_next >= nr);
	assign sts.filt_last = (i_p1 >= nr_x);
	assign sts.any_kept  = any_nx;
	assign sts.emit_last = (i_q[IDX_W-1:0] == bottom_q);

	// Row store port control: loads and filtered write-back share the write port.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = load_idx[AW-1:0];
		wr_data = row_bits & cmask;
		if (cmd.load) begin
			wr_en = 1'b1;
		end else if (cmd.filt) begin
			wr_en   = 1'b1;
			wr_addr = i_q[AW-1:0];
			wr_data = kept;
		end
		rd_en   = 1'b0;
		rd_addr = '0;
		if (cmd.prime0) begin
			rd_en = 1'b1;
		end else if (cmd.prime1) begin
			rd_en   = (nr > CNT_W'(1));
			rd_addr = AW'(1);
		end else if (cmd.filt) begin
			rd_en   = (i_p2 < nr_x);
			rd_addr = i_p2[AW-1:0];
		end else if (cmd.emit) begin
			rd_en   = 1'b1;
			rd_addr = i_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_q <= store_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q    <= CNT_W'(10);
			num_cols_q    <= CNT_W'(10);
			rows_loaded_q <= '0;
			i_q           <= '0;
			any_q         <= 1'b0;
			valid_s1      <= 1'b0;
			strobe_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_idx))
					REG_NUM_ROWS: num_rows_q <= cfg_wdata;
					REG_NUM_COLS: num_cols_q <= cfg_wdata;
					default:      num_rows_q <= num_rows_q;
				endcase
				rows_loaded_q <= '0;
			end else if (cmd.load) begin
				rows_loaded_q <= sts.load_last ? '0 : load_next;
			end
			if (cmd.prime0) begin
				i_q   <= '0;
				any_q <= 1'b0;
			end else if (cmd.filt) begin
				any_q <= any_nx;
				i_q   <= sts.filt_last ? {1'b0, top_nx} : i_p1[CNT_W-1:0];
			end else if (cmd.emit) begin
				i_q <= i_p1[CNT_W-1:0];
			end
			valid_s1 <= cmd.emit | cmd.empty;
			strobe_q <= valid_s1;
		end
	end

	assign width_w = {1'b0, right_q} - {1'b0, left_q} + CNT_W'(1);

	always_comb begin
		for (int j = 0; j < WORD_W; j++) begin
			wmask[j] = (CNT_W'(j) < width_w);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prime1) begin
			up_q  <= '0;
			cur_q <= mem_q;
		end else if (cmd.filt) begin
			up_q  <= cur_q;
			cur_q <= mem_q;
			if (|kept) begin
				bottom_q <= i_q[IDX_W-1:0];
				top_q    <= top_nx;
				left_q   <= (!any_q || lo_bit < left_q) ? lo_bit : left_q;
				right_q  <= (!any_q || hi_bit > right_q) ? hi_bit : right_q;
			end
		end
		if (cmd.emit || cmd.empty) begin
			last_s1  <= cmd.empty | sts.emit_last;
			empty_s1 <= cmd.empty;
		end
		// One result beat: the row read last cycle, cropped to the box, or zeros for an empty result.
		if (valid_s1) begin
			last_q  <= last_s1;
			empty_q <= empty_s1;
			if (empty_s1) begin
				out_row_q  <= '0;
				width_q    <= '0;
				top_out_q  <= '0;
				left_out_q <= '0;
			end else begin
				out_row_q  <= (mem_q >> left_q) & wmask;
				width_q    <= width_w;
				top_out_q  <= top_q;
				left_out_q <= left_q;
			end
		end
	end

	assign result_strobe = strobe_q;
	assign out_row_bits  = out_row_q;
	assign row_width     = width_q;
	assign box_top       = top_out_q;
	assign box_left      = left_out_q;
	assign is_last       = last_q;
	assign is_empty      = empty_q;

	a_emit_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> valid_s1)
		else $error("emit read did not enter the output stage");

	a_out_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> result_strobe)
		else $error("output stage did not present a result");

	a_empty_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && is_empty) |-> (is_last && row_width == '0 && out_row_bits == '0))
		else $error("empty result is malformed");

endmodule

@@ design/binary_neighbor_filter_bbox_crop.sv @@
// Top level of the binary neighbor filter with bounding-box crop.
//
// Rows are loaded with start while busy is low, one row per clock, into a row store
// with one read port and one write port. The row that completes num_rows starts a
// pass: states PRIME0 and PRIME1 prime the filter window, then FILT filters each row,
// writes it back and tracks the box, then EMIT reads each box row (bottom - top + 1),
// or EMPTY gives a single empty beat when nothing survives. The store's single read
// port sets the one-row-per-cycle pace of filtering and emission. Each result beat
// passes the read register and valid_s1, then the output registers, and is held for
// exactly one cycle with result_strobe high; there is no back-pressure, so the
// receiver must take every beat. Busy stays high from priming through the last EMIT
// or EMPTY state. Configuration writes restart loading and must be made only while
// the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
module binary_neighbor_filter_bbox_crop #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            cfg_we,
	input  logic [bnfc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [bnfc_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic [bnfc_pkg::WORD_W-1:0]     row_bits,
	output logic                            result_strobe,
	output logic [bnfc_pkg::WORD_W-1:0]     out_row_bits,
	output logic [bnfc_pkg::CNT_W-1:0]      row_width,
	output logic [bnfc_pkg::IDX_W-1:0]      box_top,
	output logic [bnfc_pkg::IDX_W-1:0]      box_left,
	output logic                            is_last,
	output logic                            is_empty
);
	import bnfc_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	bnfc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	bnfc_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.row_bits      (row_bits),
		.cmd           (cmd),
		.sts           (sts),
		.result_strobe (result_strobe),
		.out_row_bits  (out_row_bits),
		.row_width     (row_width),
		.box_top       (box_top),
		.box_left      (box_left),
		.is_last       (is_last),
		.is_empty      (is_empty)
	);

endmodule

@@ verif/tb_binary_neighbor_filter_bbox_crop.sv @@
// Self-checking testbench for the binary neighbor filter with bounding-box crop.
`timescale 1ns / 1ps
module tb_binary_neighbor_filter_bbox_crop;
	import bnfc_pkg::*;

	localparam int RANDOM_ROWS = 380;

	typedef struct {
		logic [WORD_W-1:0] bits;
		logic [CNT_W-1:0]  width;
		logic [IDX_W-1:0]  top;
		logic [IDX_W-1:0]  left;
		logic              last;
		logic              empty;
	} crop_beat_t;

	class crop_scoreboard;
		logic [WORD_W-1:0] land [STORE_DEPTH];
		int                rows_in;
		logic [CFG_W-1:0]  rows_reg;
		logic [CFG_W-1:0]  cols_reg;
		crop_beat_t        expected_beats [$];
		int                errors;

		function new();
			rows_in  = 0;
			rows_reg = 5'd10;
			cols_reg = 5'd10;
			errors   = 0;
		endfunction

		// Register values of zero act as one, values above sixteen as sixteen.
		function int span(logic [CFG_W-1:0] v);
			if (v == 0)
				return 1;
			if (v > 16)
				return 16;
			return int'(v);
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
			if (idx == REG_NUM_ROWS)
				rows_reg = v;
			else
				cols_reg = v;
			rows_in = 0;
		endfunction

		// Stores one accepted row; the row that completes the map runs the
		// erosion and queues the cropped rows of the surviving cells.
		function void note_row(logic [WORD_W-1:0] r);
			int                nr, nc, nb, top, bottom, left, right;
			bit                any;
			logic [WORD_W-1:0] cmask, cur, up, dn;
			logic [WORD_W-1:0] kept [STORE_DEPTH];
			crop_beat_t        b;
			nr = span(rows_reg);
			nc = span(cols_reg);
			cmask = (nc == 16) ? 16'hFFFF : ((16'd1 << nc) - 16'd1);
			if (rows_in >= nr)
				rows_in = 0;
			land[rows_in] = r & cmask;
			rows_in++;
			if (rows_in < nr)
				return;
			rows_in = 0;
			any = 0;
			top = 0;
			bottom = 0;
			left = 0;
			right = 0;
			for (int i = 0; i < nr; i++) begin
				cur = land[i];
				up = (i > 0) ? land[i-1] : '0;
				dn = (i + 1 < nr) ? land[i+1] : '0;
				kept[i] = '0;
				for (int j = 0; j < nc; j++) begin
					if (cur[j]) begin
						nb = int'(up[j]) + int'(dn[j]);
						if (j > 0)
							nb += int'(cur[j-1]);
						if (j + 1 < nc)
							nb += int'(cur[j+1]);
						if (NEIGHBORS - nb < SURVIVE_LIMIT) begin
							kept[i][j] = 1'b1;
							if (!any) begin
								top = i;
								left = j;
								right = j;
								any = 1;
							end
							if (j < left)
								left = j;
							if (j > right)
								right = j;
							bottom = i;
						end
					end
				end
			end
			if (!any) begin
				b = '{bits: '0, width: '0, top: '0, left: '0, last: 1'b1, empty: 1'b1};
				expected_beats.push_back(b);
				return;
			end
			for (int i = top; i <= bottom; i++) begin
				b.bits  = kept[i] >> left;
				b.width = CNT_W'(right - left + 1);
				b.top   = IDX_W'(top);
				b.left  = IDX_W'(left);
				b.last  = (i == bottom);
				b.empty = 1'b0;
				expected_beats.push_back(b);
			end
		endfunction

		function void compare(string field, int exp_v, int act_v);
			if (exp_v != act_v) begin
				$error("%s mismatch: expected %0d, actual %0d", field, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(crop_beat_t got);
			crop_beat_t want;
			if (expected_beats.size() == 0) begin
				$error("result beat with no expected beat: out_row_bits %h", got.bits);
				errors++;
				return;
			end
			want = expected_beats.pop_front();
			compare("out_row_bits", want.bits, got.bits);
			compare("row_width", want.width, got.width);
			compare("box_top", want.top, got.top);
			compare("box_left", want.left, got.left);
			compare("is_last", want.last, got.last);
			compare("is_empty", want.empty, got.empty);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              cfg_we = 1'b0;
	cfg_reg_t          cfg_idx = REG_NUM_ROWS;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic [WORD_W-1:0] row_bits = '0;
	logic              result_strobe;
	logic [WORD_W-1:0] out_row_bits;
	logic [CNT_W-1:0]  row_width;
	logic [IDX_W-1:0]  box_top;
	logic [IDX_W-1:0]  box_left;
	logic              is_last;
	logic              is_empty;

	crop_scoreboard sb = new();
	crop_beat_t     seen;
	bit             idle_on = 0;
	int             rows_sent = 0;

	binary_neighbor_filter_bbox_crop u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.row_bits      (row_bits),
		.result_strobe (result_strobe),
		.out_row_bits  (out_row_bits),
		.row_width     (row_width),
		.box_top       (box_top),
		.box_left      (box_left),
		.is_last       (is_last),
		.is_empty      (is_empty)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Everything is sampled with its value from before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_strobe) begin
				seen.bits  = out_row_bits;
				seen.width = row_width;
				seen.top   = box_top;
				seen.left  = box_left;
				seen.last  = is_last;
				seen.empty = is_empty;
				sb.check_result(seen);
			end
			if (cfg_we)
				sb.write_reg(cfg_idx, cfg_wdata);
			if (start && !busy)
				sb.note_row(row_bits);
		end
	end

	task automatic send_row(input logic [WORD_W-1:0] r);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		row_bits <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		rows_sent++;
	endtask

	// Waits out every expected beat, then the pass that a row without a
	// result may still have running.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_both(input logic [CFG_W-1:0] nrows, input logic [CFG_W-1:0] ncols);
		settle();
		cfg_we <= 1'b1;
		cfg_idx <= REG_NUM_ROWS;
		cfg_wdata <= nrows;
		@(posedge clk);
		cfg_idx <= REG_NUM_COLS;
		cfg_wdata <= ncols;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [WORD_W-1:0] make_row(int mode);
		case (mode)
			0: return WORD_W'($urandom);
			1: return '1;
			2: return '0;
			3: return WORD_W'($urandom | $urandom);
			4: return WORD_W'($urandom & $urandom);
			default: return WORD_W'($urandom | $urandom | $urandom);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_count();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0)
			return $urandom_range(0, 1) ? CFG_W'(0) : CFG_W'($urandom_range(17, 31));
		if (k == 1)
			return CFG_W'(16);
		if (k == 2)
			return CFG_W'(1);
		return CFG_W'($urandom_range(1, 16));
	endfunction

	initial begin
		int nr, mode, maps;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry of ten by ten, fully land.
		repeat (10) send_row('1);
		// A lone cell never survives, and bits past the columns in use are water.
		write_both(5'd1, 5'd1);
		send_row(16'h0001);
		send_row(16'hFFFE);
		write_both(5'd2, 5'd2);
		send_row('1);
		send_row('1);
		// Zero rows act as one; oversized column count acts as sixteen.
		write_both(5'd0, 5'd31);
		send_row('1);
		// A configuration write drops the rows loaded so far.
		write_both(5'd3, 5'd3);
		send_row(16'h0007);
		send_row(16'h0007);
		write_both(5'd2, 5'd16);
		send_row(16'hC003);
		send_row(16'hC003);

		while (rows_sent < RANDOM_ROWS) begin
			idle_on = (rows_sent < RANDOM_ROWS - 40) && ($urandom_range(0, 3) != 0);
			write_both(pick_count(), pick_count());
			nr = sb.span(sb.rows_reg);
			maps = $urandom_range(1, 4);
			for (int m = 0; m < maps; m++) begin
				mode = $urandom_range(0, 5);
				for (int i = 0; i < nr; i++)
					send_row(make_row(mode));
			end
			// Now and then leave a map unfinished for the next write to discard.
			if (nr > 1 && $urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, nr - 1)) send_row(make_row(0));
		end

		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("binary_neighbor_filter_bbox_crop regression: pass");
		else
			$display("binary_neighbor_filter_bbox_crop regression: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("binary_neighbor_filter_bbox_crop regression: fail");
		$finish;
	end

endmodule
